### src/otwp_pkg.sv
// Package for the one-wire temperature poller: constants, codes and shared types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package otwp_pkg;

   localparam int SENSOR_COUNT     = 4;
   localparam int IDX_W            = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
   localparam int SCRATCHPAD_BYTES = 9;
   localparam int STORE_W          = 32;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   localparam logic [9:0] RESET_LOW_DEFAULT = 10'd480;
   localparam logic [9:0] PRESENCE_DEFAULT  = 10'd66;
   localparam logic [7:0] SLOT_DEFAULT      = 8'd60;
   localparam logic [7:0] SAMPLE_DEFAULT    = 8'd15;
   localparam logic [7:0] START_LOW_DEFAULT = 8'd1;

   localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
   localparam logic [7:0] CMD_CONVERT  = 8'h44;
   localparam logic [7:0] CMD_READ_PAD = 8'hBE;
   localparam logic [7:0] READ_PATTERN = 8'hFF;

   localparam logic [3:0] BYTE_TEMP_LSB   = 4'd0;
   localparam logic [3:0] BYTE_TEMP_MSB   = 4'd1;
   localparam logic [3:0] BYTE_COUNT_REM  = 4'd6;
   localparam logic [3:0] BYTE_COUNT_PER  = 4'd7;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RESET_LOW    = 3'd0,
      CSR_PRESENCE     = 3'd1,
      CSR_SLOT         = 3'd2,
      CSR_SAMPLE       = 3'd3,
      CSR_START_LOW    = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'b001,
      PH_CONVERTING = 3'b010,
      PH_READING    = 3'b100
   } phase_type;

   typedef enum logic [6:0] {
      ST_START    = 7'b0000001,
      ST_RST_LOW  = 7'b0000010,
      ST_RST_PRES = 7'b0000100,
      ST_RST_REC  = 7'b0001000,
      ST_SKIP     = 7'b0010000,
      ST_CMD      = 7'b0100000,
      ST_DATA     = 7'b1000000
   } step_type;

   typedef struct packed {
      logic [9:0] reset_low_ticks;
      logic [9:0] presence_sample_ticks;
      logic [7:0] slot_ticks;
      logic [7:0] sample_ticks;
      logic [7:0] start_low_ticks;
   } cfg_type;

   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   idx;
      logic [STORE_W-1:0] data;
   } store_wr_type;

endpackage

`default_nettype wire

### src/otwp_csr.sv
// Timing register bank of the one-wire temperature poller.
// Depends on otwp_pkg for the register codes and the configuration struct.
`default_nettype none

module otwp_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [otwp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [otwp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output otwp_pkg::cfg_type                      cfg
);

   otwp_pkg::cfg_type cfg_ff;
   otwp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            otwp_pkg::CSR_RESET_LOW: cfg_in.reset_low_ticks       = csr_wdata[9:0];
            otwp_pkg::CSR_PRESENCE:  cfg_in.presence_sample_ticks = csr_wdata[9:0];
            otwp_pkg::CSR_SLOT:      cfg_in.slot_ticks            = csr_wdata[7:0];
            otwp_pkg::CSR_SAMPLE:    cfg_in.sample_ticks          = csr_wdata[7:0];
            otwp_pkg::CSR_START_LOW: cfg_in.start_low_ticks       = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks       <= otwp_pkg::RESET_LOW_DEFAULT;
         cfg_ff.presence_sample_ticks <= otwp_pkg::PRESENCE_DEFAULT;
         cfg_ff.slot_ticks            <= otwp_pkg::SLOT_DEFAULT;
         cfg_ff.sample_ticks          <= otwp_pkg::SAMPLE_DEFAULT;
         cfg_ff.start_low_ticks       <= otwp_pkg::START_LOW_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### src/otwp_store.sv
// Per-sensor store of the last good reading (scratchpad bytes 0, 1, 6 and 7).
// Depends on otwp_pkg; the value shown already includes a write in the same tick.
`default_nettype none

module otwp_store (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire otwp_pkg::store_wr_type         wr,
   input  wire logic [1:0]                     sensor_select,
   output logic [otwp_pkg::STORE_W-1:0]        shown
);

   logic [otwp_pkg::STORE_W-1:0] store_ff [otwp_pkg::SENSOR_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < otwp_pkg::SENSOR_COUNT; i++) begin
            store_ff[i] <= '0;
         end
      end else if (wr.en) begin
         store_ff[wr.idx] <= wr.data;
      end
   end

   always_comb begin
      shown = '0;
      if (32'(sensor_select) < otwp_pkg::SENSOR_COUNT) begin
         if (wr.en && (32'(wr.idx) == 32'(sensor_select))) begin
            shown = wr.data;
         end else begin
            shown = store_ff[sensor_select[otwp_pkg::IDX_W-1:0]];
         end
      end
   end

endmodule

`default_nettype wire

### src/otwp_ctrl.sv
// Bus sequencer of the one-wire temperature poller: reset pulses, bit slots,
// command and read bytes, CRC check and sensor rotation, one tick per enable.
// Depends on otwp_pkg for codes, the configuration struct and the store write struct.
`default_nettype none

module otwp_ctrl (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               en,
   input  wire logic [otwp_pkg::SENSOR_COUNT-1:0]  line_levels,
   input  wire otwp_pkg::cfg_type                  cfg,
   output logic [otwp_pkg::SENSOR_COUNT-1:0]       drive_low,
   output otwp_pkg::store_wr_type                  store_wr
);

   localparam int IW = otwp_pkg::IDX_W;

   logic [IW-1:0]       index_ff, index_in;
   otwp_pkg::phase_type phase_ff [otwp_pkg::SENSOR_COUNT];
   otwp_pkg::phase_type phase_in [otwp_pkg::SENSOR_COUNT];
   otwp_pkg::step_type  step_ff, step_in;
   logic [9:0]          tick_ff, tick_in;
   logic [2:0]          bit_ff, bit_in;
   logic [3:0]          byte_ff, byte_in;
   logic [7:0]          shift_ff, shift_in;
   logic [7:0]          crc_ff, crc_in;
   logic                pf_ff, pf_in;
   logic                sent_ff, sent_in;
   logic [7:0]          scratch_ff [4];
   logic [7:0]          scratch_in [4];

   logic [IW-1:0]       idx;
   otwp_pkg::phase_type phase;
   logic                line;
   logic                drive;
   logic                byte_done;
   logic                finish;
   logic [9:0]          n;
   logic [9:0]          lo, pr, target;
   logic [7:0]          smp, slot, stl;

   function automatic logic [9:0] max1_10(input logic [9:0] v);
      return (v == '0) ? 10'd1 : v;
   endfunction

   function automatic logic [7:0] max1_8(input logic [7:0] v);
      return (v == '0) ? 8'd1 : v;
   endfunction

   // Dallas/Maxim CRC-8, reflected polynomial 0x8C, one byte at a time.
   function automatic logic [7:0] crc_feed(input logic [7:0] c, input logic [7:0] b);
      logic [7:0] r;
      r = c ^ b;
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ 8'h8C) : (r >> 1);
      end
      return r;
   endfunction

   always_comb begin
      index_in   = index_ff;
      phase_in   = phase_ff;
      step_in    = step_ff;
      tick_in    = tick_ff;
      bit_in     = bit_ff;
      byte_in    = byte_ff;
      shift_in   = shift_ff;
      crc_in     = crc_ff;
      pf_in      = pf_ff;
      sent_in    = sent_ff;
      scratch_in = scratch_ff;
      store_wr   = '0;
      drive      = 1'b0;
      byte_done  = 1'b0;
      finish     = 1'b0;
      n          = '0;
      target     = 10'd1;

      idx   = (32'(index_ff) >= otwp_pkg::SENSOR_COUNT) ? '0 : index_ff;
      phase = phase_ff[idx];
      line  = line_levels[idx];
      lo    = max1_10(cfg.reset_low_ticks);
      pr    = max1_10(cfg.presence_sample_ticks);
      smp   = max1_8(cfg.sample_ticks);
      slot  = max1_8(cfg.slot_ticks);
      stl   = max1_8(cfg.start_low_ticks);

      if (step_ff == otwp_pkg::ST_START || !$onehot(step_ff)) begin
         step_in = otwp_pkg::ST_START;
         tick_in = '0;
         if (phase == otwp_pkg::PH_IDLE || phase == otwp_pkg::PH_READING) begin
            step_in = otwp_pkg::ST_RST_LOW;
         end else if (phase == otwp_pkg::PH_CONVERTING) begin
            step_in  = otwp_pkg::ST_DATA;
            shift_in = otwp_pkg::READ_PATTERN;
            bit_in   = '0;
         end else begin
            finish = 1'b1;
         end
      end

      // One tick of a bit slot, shared by the command and data bytes.
      if (step_in == otwp_pkg::ST_SKIP || step_in == otwp_pkg::ST_CMD ||
          step_in == otwp_pkg::ST_DATA) begin
         n = tick_in + 10'd1;
         if (n == 10'd1) begin
            sent_in = shift_in[0];
         end
         drive = (n <= {2'b00, stl}) || !sent_in;
         if (n == {2'b00, smp}) begin
            shift_in[0] = sent_in & line;
         end
         if (n >= {2'b00, slot} && n >= {2'b00, smp}) begin
            shift_in  = {shift_in[0], shift_in[7:1]};
            bit_in    = bit_in + 3'd1;
            tick_in   = '0;
            byte_done = (bit_in == 3'd0);
         end else begin
            tick_in = n;
         end
      end

      unique case (step_in)
         otwp_pkg::ST_START: ;
         otwp_pkg::ST_RST_LOW: begin
            drive   = 1'b1;
            tick_in = tick_in + 10'd1;
            if (tick_in >= lo) begin
               step_in = otwp_pkg::ST_RST_PRES;
               tick_in = '0;
            end
         end
         otwp_pkg::ST_RST_PRES: begin
            tick_in = tick_in + 10'd1;
            if (tick_in >= pr) begin
               pf_in   = line;
               step_in = otwp_pkg::ST_RST_REC;
               tick_in = '0;
            end
         end
         otwp_pkg::ST_RST_REC: begin
            target  = (lo > pr) ? (lo - pr) : 10'd1;
            tick_in = tick_in + 10'd1;
            if (tick_in >= target) begin
               if (!line) begin
                  pf_in = 1'b1;
               end
               if (pf_in) begin
                  phase_in[idx] = (phase == otwp_pkg::PH_READING) ?
                                  otwp_pkg::PH_IDLE : otwp_pkg::PH_CONVERTING;
                  finish = 1'b1;
               end else begin
                  step_in  = otwp_pkg::ST_SKIP;
                  shift_in = otwp_pkg::CMD_SKIP_ROM;
                  bit_in   = '0;
                  tick_in  = '0;
               end
            end
         end
         otwp_pkg::ST_SKIP: begin
            if (byte_done) begin
               step_in  = otwp_pkg::ST_CMD;
               shift_in = (phase == otwp_pkg::PH_READING) ?
                          otwp_pkg::CMD_READ_PAD : otwp_pkg::CMD_CONVERT;
               bit_in   = '0;
               tick_in  = '0;
            end
         end
         otwp_pkg::ST_CMD: begin
            if (byte_done) begin
               if (phase == otwp_pkg::PH_READING) begin
                  step_in  = otwp_pkg::ST_DATA;
                  byte_in  = '0;
                  crc_in   = '0;
                  shift_in = otwp_pkg::READ_PATTERN;
                  bit_in   = '0;
                  tick_in  = '0;
               end else begin
                  phase_in[idx] = otwp_pkg::PH_CONVERTING;
                  finish        = 1'b1;
               end
            end
         end
         otwp_pkg::ST_DATA: begin
            if (byte_done) begin
               if (phase != otwp_pkg::PH_READING) begin
                  if (shift_in == otwp_pkg::READ_PATTERN) begin
                     phase_in[idx] = otwp_pkg::PH_READING;
                  end
                  finish = 1'b1;
               end else begin
                  unique case (byte_in)
                     otwp_pkg::BYTE_TEMP_LSB:  scratch_in[0] = shift_in;
                     otwp_pkg::BYTE_TEMP_MSB:  scratch_in[1] = shift_in;
                     otwp_pkg::BYTE_COUNT_REM: scratch_in[2] = shift_in;
                     otwp_pkg::BYTE_COUNT_PER: scratch_in[3] = shift_in;
                     default: ;
                  endcase
                  crc_in  = crc_feed(crc_in, shift_in);
                  byte_in = byte_in + 4'd1;
                  if (32'(byte_in) >= otwp_pkg::SCRATCHPAD_BYTES) begin
                     if (crc_in == '0) begin
                        store_wr.en   = en;
                        store_wr.idx  = idx;
                        store_wr.data = {scratch_in[3], scratch_in[2],
                                         scratch_in[1], scratch_in[0]};
                        phase_in[idx] = otwp_pkg::PH_IDLE;
                     end
                     finish = 1'b1;
                  end else begin
                     shift_in = otwp_pkg::READ_PATTERN;
                     bit_in   = '0;
                     tick_in  = '0;
                  end
               end
            end
         end
         default: ;
      endcase

      if (finish) begin
         step_in  = otwp_pkg::ST_START;
         tick_in  = '0;
         index_in = (32'(idx) == otwp_pkg::SENSOR_COUNT - 1) ? '0 : idx + IW'(1);
      end
   end

   assign drive_low = drive ? (otwp_pkg::SENSOR_COUNT'(1) << idx) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         for (int i = 0; i < otwp_pkg::SENSOR_COUNT; i++) begin
            phase_ff[i] <= otwp_pkg::PH_IDLE;
         end
         step_ff  <= otwp_pkg::ST_START;
         tick_ff  <= '0;
         bit_ff   <= '0;
         byte_ff  <= '0;
         shift_ff <= '0;
         crc_ff   <= '0;
         pf_ff    <= 1'b0;
         sent_ff  <= 1'b0;
      end else if (en) begin
         index_ff <= index_in;
         phase_ff <= phase_in;
         step_ff  <= step_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         shift_ff <= shift_in;
         crc_ff   <= crc_in;
         pf_ff    <= pf_in;
         sent_ff  <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         scratch_ff <= scratch_in;
      end
   end

   // A byte is only part-way through its bits while a slot step is running.
   a_bit_in_slot: assert property (@(posedge clock) disable iff (reset)
      (bit_ff != '0) |-> (step_ff == otwp_pkg::ST_SKIP || step_ff == otwp_pkg::ST_CMD ||
                          step_ff == otwp_pkg::ST_DATA))
      else $error("bit count set outside a byte transfer");

   a_byte_range: assert property (@(posedge clock) disable iff (reset)
      32'(byte_ff) <= otwp_pkg::SCRATCHPAD_BYTES)
      else $error("scratchpad byte count beyond nine");

   a_store_ends_visit: assert property (@(posedge clock) disable iff (reset)
      store_wr.en |=> (step_ff == otwp_pkg::ST_START))
      else $error("reading stored without ending the visit");

endmodule

`default_nettype wire

### src/one_wire_temperature_poller.sv
// Top level of the one-wire temperature poller: stream ports, input and result registers.
// Depends on otwp_pkg, otwp_csr, otwp_ctrl and otwp_store.
//
// Each request word is one timing tick: it carries the sampled levels of the four sensor
// lines and the sensor whose stored reading is to be shown, and it produces exactly one
// response word with the open-drain enables for that tick and the stored bytes. A word can
// be taken on every clock cycle unless a response word waits with rsp_tready low; each word
// passes through the input register and then the response register, with back-pressure
// from rsp_tready stalling both registers together. The store of readings is cleared by
// reset and needs no clearing pass. The timing registers are written through the csr port;
// the user must write them only while no word is in flight, as the block has no check for it.
`default_nettype none

module one_wire_temperature_poller (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // line_levels [3:0], sensor_select [5:4], zero [7:6]
   input  wire logic [otwp_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // drive_low [3:0], temp_lsb [11:4], temp_msb [19:12], remain_count [27:20],
   // count_per_degree [35:28], zero [39:36]
   output logic [otwp_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   input  wire logic                              csr_we,
   input  wire logic [otwp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [otwp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic                                  advance;
   logic                                  fire;
   logic                                  s1_valid_ff;
   logic [otwp_pkg::SENSOR_COUNT-1:0]     s1_levels_ff;
   logic [1:0]                            s1_select_ff;
   logic                                  rsp_valid_ff;
   logic [otwp_pkg::RSP_TDATA_W-1:0]      rsp_data_ff;
   logic [otwp_pkg::RSP_TDATA_W-1:0]      rsp_data_in;

   otwp_pkg::cfg_type                     cfg;
   otwp_pkg::store_wr_type                store_wr;
   logic [otwp_pkg::SENSOR_COUNT-1:0]     drive_low;
   logic [otwp_pkg::STORE_W-1:0]          shown;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = advance && s1_valid_ff;
   assign req_tready = advance;

   otwp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   otwp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .en          (fire),
      .line_levels (s1_levels_ff),
      .cfg         (cfg),
      .drive_low   (drive_low),
      .store_wr    (store_wr)
   );

   otwp_store u_store (
      .clock         (clock),
      .reset         (reset),
      .wr            (store_wr),
      .sensor_select (s1_select_ff),
      .shown         (shown)
   );

   assign rsp_data_in = {4'b0000, shown, 4'(drive_low)};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_tvalid;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_tvalid) begin
         s1_levels_ff <= req_tdata[3:0];
         s1_select_ff <= req_tdata[5:4];
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_fire_gives_word: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_tvalid)
      else $error("processed tick produced no response word");

   a_one_line_driven: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[3:0]))
      else $error("more than one sensor line driven low");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff)
      else $error("input register lost a word while stalled");

endmodule

`default_nettype wire
